// ===== rtl/monotone_cubic_upsampler_top_defines.svh =====
// ----------------------------------------------------------------------------
// Monotone cubic upsampler assertion macros
// Shared assertion forms, clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef MONOTONE_CUBIC_UPSAMPLER_TOP_DEFINES_SVH
`define MONOTONE_CUBIC_UPSAMPLER_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define MCU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define MCU_NEVER(lbl, cond, msg) \
  `MCU_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/mcu_pkg.sv =====
// ----------------------------------------------------------------------------
// Monotone cubic upsampler package
// Widths, basis weight table and the types shared by the front end, the
// queues and the back end.
// ----------------------------------------------------------------------------
package mcu_pkg;

  localparam int unsigned SUBSTEPS   = 6;
  localparam int unsigned MAX_POINTS = 64;

  localparam int unsigned SampleW = 15;
  localparam int unsigned PosW    = 9;
  localparam int unsigned SlopeW  = 18;
  localparam int unsigned WeightW = 17;
  localparam int unsigned KW      = $clog2(SUBSTEPS);
  localparam int unsigned ProdPW  = WeightW + SampleW + 2;
  localparam int unsigned ProdMW  = WeightW + SlopeW;
  localparam int unsigned AccW    = 40;
  localparam int unsigned FracW   = 16;
  localparam int unsigned RoundBias = 1 << (FracW - 1);

  localparam int unsigned ValMax    = 25600;
  localparam int unsigned PosMaxRaw = (MAX_POINTS - 1) * SUBSTEPS;
  localparam int unsigned PosMax    = (PosMaxRaw > 511) ? 511 : PosMaxRaw;

  localparam longint Den  = SUBSTEPS * SUBSTEPS * SUBSTEPS;
  localparam longint Den2 = 2 * Den;

  localparam int unsigned CmdDepth = 2;
  localparam int unsigned CmdPtrW  = $clog2(CmdDepth);
  localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);
  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW  = $clog2(ResDepth);
  localparam int unsigned ResCntW  = $clog2(ResDepth + 1);

  typedef logic [SampleW-1:0]        sample_t;
  typedef logic [PosW-1:0]           pos_t;
  typedef logic signed [SlopeW-1:0]  slope_t;
  typedef logic signed [WeightW-1:0] weight_t;

  typedef struct packed {
    weight_t w00;
    weight_t w10;
    weight_t w01;
    weight_t w11;
  } basis_t;

  typedef basis_t [SUBSTEPS-1:0] basis_tab_t;

  typedef enum logic [1:0] {
    PH_GAP1,
    PH_GAP2,
    PH_END
  } phase_e;

  // One accepted sample's work: up to two gaps and the window end point.
  // The second gap runs from p2 to last with slopes m2 and zero.
  typedef struct packed {
    logic    has_gap1;
    logic    has_gap2;
    logic    has_end;
    sample_t p1;
    sample_t p2;
    slope_t  m1;
    slope_t  m2;
    sample_t last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    sample_t value;
    pos_t    pos;
    logic    fin;
  } res_t;

  function automatic weight_t q15_of(longint num);
    longint mag;
    longint r;
    mag = (num < 0) ? -num : num;
    r = (mag * 65536 + Den) / Den2;
    return (num < 0) ? weight_t'(-r) : weight_t'(r);
  endfunction

  function automatic basis_tab_t build_basis();
    basis_tab_t tab;
    longint s;
    longint k;
    longint k2;
    longint k3;
    s = SUBSTEPS;
    for (int i = 0; i < SUBSTEPS; i++) begin
      k  = i;
      k2 = k * k;
      k3 = k2 * k;
      tab[i].w00 = q15_of(2 * k3 - 3 * k2 * s + Den);
      tab[i].w10 = q15_of(k3 - 2 * k2 * s + k * s * s);
      tab[i].w01 = q15_of(3 * k2 * s - 2 * k3);
      tab[i].w11 = q15_of(k3 - k2 * s);
    end
    return tab;
  endfunction

  localparam basis_tab_t Basis = build_basis();

endpackage

// ===== rtl/mcu_front.sv =====
// ----------------------------------------------------------------------------
// Monotone cubic upsampler front end
// Accepts samples, keeps the last two of the window, computes slopes and
// queues the gaps and end point that each sample releases.
// ----------------------------------------------------------------------------
module mcu_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mcu_pkg::sample_t sample_i,
  input  logic            end_of_window_i,
  input  logic            cmd_full_i,
  output logic            cmd_push_o,
  output mcu_pkg::cmd_t   cmd_o
);

  function automatic mcu_pkg::slope_t half_slope(mcu_pkg::sample_t prev,
                                                 mcu_pkg::sample_t cur,
                                                 mcu_pkg::sample_t next);
    logic signed [mcu_pkg::SampleW:0]   diff_in;
    logic signed [mcu_pkg::SampleW:0]   diff_out;
    logic [mcu_pkg::SampleW-1:0]        ab;
    logic [mcu_pkg::SampleW-1:0]        aa;
    logic [mcu_pkg::SampleW-1:0]        mn;
    logic signed [mcu_pkg::SampleW+4:0] lim;
    logic signed [mcu_pkg::SampleW+4:0] s;
    diff_in  = $signed({1'b0, cur}) - $signed({1'b0, prev});
    diff_out = $signed({1'b0, next}) - $signed({1'b0, cur});
    ab = diff_in[mcu_pkg::SampleW] ? mcu_pkg::SampleW'(-diff_in)
                                   : mcu_pkg::SampleW'(diff_in);
    aa = diff_out[mcu_pkg::SampleW] ? mcu_pkg::SampleW'(-diff_out)
                                    : mcu_pkg::SampleW'(diff_out);
    mn = (ab < aa) ? ab : aa;
    lim = ($signed({5'd0, mn}) <<< 2) + ($signed({5'd0, mn}) <<< 1);
    s = (mcu_pkg::SampleW + 5)'(diff_in) + (mcu_pkg::SampleW + 5)'(diff_out);
    if (diff_in == '0 || diff_out == '0 ||
        (diff_in[mcu_pkg::SampleW] != diff_out[mcu_pkg::SampleW])) begin
      return '0;
    end
    if (s > lim) begin
      s = lim;
    end else if (s < -lim) begin
      s = -lim;
    end
    return mcu_pkg::slope_t'(s);
  endfunction

  logic [1:0]       seen_q, seen_d;
  mcu_pkg::slope_t  slope_q, slope_d;
  mcu_pkg::sample_t middle_q, middle_d;
  mcu_pkg::sample_t newest_q, newest_d;
  mcu_pkg::slope_t  m_new;
  logic             accept;

  assign accept = push_i & ~cmd_full_i;
  assign m_new  = half_slope(middle_q, newest_q, sample_i);

  always_comb begin
    seen_d     = seen_q;
    slope_d    = slope_q;
    middle_d   = middle_q;
    newest_d   = newest_q;
    cmd_push_o = 1'b0;
    cmd_o      = '0;
    cmd_o.last = sample_i;
    if (accept) begin
      case (seen_q)
        2'd0: begin
          if (end_of_window_i) begin
            cmd_push_o    = 1'b1;
            cmd_o.has_end = 1'b1;
          end else begin
            newest_d = sample_i;
            seen_d   = 2'd1;
          end
        end
        2'd1: begin
          if (end_of_window_i) begin
            cmd_push_o     = 1'b1;
            cmd_o.has_gap1 = 1'b1;
            cmd_o.has_end  = 1'b1;
            cmd_o.p1       = newest_q;
            cmd_o.p2       = sample_i;
            seen_d         = 2'd0;
          end else begin
            middle_d = newest_q;
            newest_d = sample_i;
            seen_d   = 2'd2;
          end
        end
        default: begin
          cmd_push_o     = 1'b1;
          cmd_o.has_gap1 = 1'b1;
          cmd_o.p1       = middle_q;
          cmd_o.p2       = newest_q;
          cmd_o.m1       = slope_q;
          cmd_o.m2       = m_new;
          if (end_of_window_i) begin
            cmd_o.has_gap2 = 1'b1;
            cmd_o.has_end  = 1'b1;
            seen_d         = 2'd0;
            slope_d        = '0;
          end else begin
            middle_d = newest_q;
            newest_d = sample_i;
            slope_d  = m_new;
            seen_d   = 2'd3;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      slope_q <= '0;
    end else begin
      seen_q  <= seen_d;
      slope_q <= slope_d;
    end
  end

  always_ff @(posedge clk_i) begin
    middle_q <= middle_d;
    newest_q <= newest_d;
  end

endmodule

// ===== rtl/mcu_cmdq.sv =====
// ----------------------------------------------------------------------------
// Monotone cubic upsampler command queue
// Short queue of gap commands between the front end and the back end.
// ----------------------------------------------------------------------------
module mcu_cmdq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mcu_pkg::cmd_t    cmd_i,
  input  logic             pop_i,
  output mcu_pkg::cmd_t    head_o,
  output mcu_pkg::q_stat_t stat_o
);

  mcu_pkg::cmd_t                 mem_q [mcu_pkg::CmdDepth];
  logic [mcu_pkg::CmdPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [mcu_pkg::CmdCntW-1:0]   count_q;
  logic                          do_push, do_pop;

  assign stat_o.full  = (count_q == mcu_pkg::CmdCntW'(mcu_pkg::CmdDepth));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i & ~stat_o.full;
  assign do_pop       = pop_i & ~stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + mcu_pkg::CmdCntW'(do_push) - mcu_pkg::CmdCntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== rtl/mcu_back.sv =====
// ----------------------------------------------------------------------------
// Monotone cubic upsampler back end
// Steps through each queued gap's substeps, weights the end samples and slopes
// by the basis table, rounds and saturates one word per cycle unless stalled.
// ----------------------------------------------------------------------------
module mcu_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mcu_pkg::cmd_t               cmd_i,
  input  logic                        cmd_valid_i,
  output logic                        cmd_pop_o,
  input  logic [mcu_pkg::ResCntW-1:0] res_count_i,
  output logic                        res_push_o,
  output mcu_pkg::res_t               res_o
);

  mcu_pkg::phase_e            phase_q, phase_d, phase;
  logic [mcu_pkg::KW-1:0]     k_q, k_d;
  mcu_pkg::pos_t              pos_q, pos_d;
  logic                       issue, last_k;
  mcu_pkg::sample_t           op_p1, op_p2;
  mcu_pkg::slope_t            op_m1, op_m2;
  logic                       op_end;
  mcu_pkg::basis_t            w;

  logic                             s1_v_q;
  logic                             s1_end_q;
  mcu_pkg::sample_t                 s1_endval_q;
  mcu_pkg::pos_t                    s1_pos_q;
  logic signed [mcu_pkg::ProdPW-1:0] s1_p00_q, s1_p01_q;
  logic signed [mcu_pkg::ProdMW-1:0] s1_p10_q, s1_p11_q;

  logic signed [mcu_pkg::AccW-1:0]  acc, rnd;
  logic [mcu_pkg::AccW-mcu_pkg::FracW-1:0] v;

  assign issue  = cmd_valid_i &&
                  (({1'b0, res_count_i} + (mcu_pkg::ResCntW + 1)'(s1_v_q)) <
                   (mcu_pkg::ResCntW + 1)'(mcu_pkg::ResDepth));
  assign last_k = (k_q == mcu_pkg::KW'(mcu_pkg::SUBSTEPS - 1));
  assign phase  = (phase_q == mcu_pkg::PH_GAP1 && !cmd_i.has_gap1) ? mcu_pkg::PH_END
                                                                    : phase_q;
  assign w      = mcu_pkg::Basis[k_q];

  always_comb begin
    phase_d   = phase_q;
    k_d       = k_q;
    cmd_pop_o = 1'b0;
    if (issue) begin
      unique case (phase)
        mcu_pkg::PH_GAP1: begin
          if (last_k) begin
            k_d = '0;
            if (cmd_i.has_gap2) begin
              phase_d = mcu_pkg::PH_GAP2;
            end else if (cmd_i.has_end) begin
              phase_d = mcu_pkg::PH_END;
            end else begin
              phase_d   = mcu_pkg::PH_GAP1;
              cmd_pop_o = 1'b1;
            end
          end else begin
            k_d = k_q + 1'b1;
          end
        end
        mcu_pkg::PH_GAP2: begin
          if (last_k) begin
            k_d = '0;
            if (cmd_i.has_end) begin
              phase_d = mcu_pkg::PH_END;
            end else begin
              phase_d   = mcu_pkg::PH_GAP1;
              cmd_pop_o = 1'b1;
            end
          end else begin
            k_d = k_q + 1'b1;
          end
        end
        mcu_pkg::PH_END: begin
          phase_d   = mcu_pkg::PH_GAP1;
          k_d       = '0;
          cmd_pop_o = 1'b1;
        end
        default: begin
          phase_d = mcu_pkg::PH_GAP1;
          k_d     = '0;
        end
      endcase
    end
  end

  always_comb begin
    op_p1  = cmd_i.p1;
    op_p2  = cmd_i.p2;
    op_m1  = cmd_i.m1;
    op_m2  = cmd_i.m2;
    op_end = 1'b0;
    unique case (phase)
      mcu_pkg::PH_GAP1: begin
        op_end = 1'b0;
      end
      mcu_pkg::PH_GAP2: begin
        op_p1 = cmd_i.p2;
        op_p2 = cmd_i.last;
        op_m1 = cmd_i.m2;
        op_m2 = '0;
      end
      mcu_pkg::PH_END: begin
        op_end = 1'b1;
      end
      default: begin
        op_end = 1'b0;
      end
    endcase
  end

  always_comb begin
    pos_d = pos_q;
    if (issue) begin
      if (op_end) begin
        pos_d = '0;
      end else if (pos_q < mcu_pkg::PosW'(mcu_pkg::PosMax)) begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mcu_pkg::PH_GAP1;
      k_q     <= '0;
      pos_q   <= '0;
      s1_v_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      k_q     <= k_d;
      pos_q   <= pos_d;
      s1_v_q  <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_end_q    <= op_end;
      s1_endval_q <= (cmd_i.last > mcu_pkg::SampleW'(mcu_pkg::ValMax))
                     ? mcu_pkg::SampleW'(mcu_pkg::ValMax) : cmd_i.last;
      s1_pos_q    <= pos_q;
      s1_p00_q    <= w.w00 * $signed({1'b0, op_p1, 1'b0});
      s1_p01_q    <= w.w01 * $signed({1'b0, op_p2, 1'b0});
      s1_p10_q    <= w.w10 * op_m1;
      s1_p11_q    <= w.w11 * op_m2;
    end
  end

  assign acc = mcu_pkg::AccW'(s1_p00_q) + mcu_pkg::AccW'(s1_p01_q)
             + mcu_pkg::AccW'(s1_p10_q) + mcu_pkg::AccW'(s1_p11_q);
  assign rnd = acc + mcu_pkg::AccW'(mcu_pkg::RoundBias);
  assign v   = rnd[mcu_pkg::AccW-1:mcu_pkg::FracW];

  always_comb begin
    res_o.pos = s1_pos_q;
    res_o.fin = s1_end_q;
    if (s1_end_q) begin
      res_o.value = s1_endval_q;
    end else if (acc < 0) begin
      res_o.value = '0;
    end else if (v > (mcu_pkg::AccW - mcu_pkg::FracW)'(mcu_pkg::ValMax)) begin
      res_o.value = mcu_pkg::SampleW'(mcu_pkg::ValMax);
    end else begin
      res_o.value = mcu_pkg::SampleW'(v);
    end
  end

  assign res_push_o = s1_v_q;

endmodule

// ===== rtl/mcu_resq.sv =====
// ----------------------------------------------------------------------------
// Monotone cubic upsampler result queue
// Holds finished words until the consumer pops them.
// ----------------------------------------------------------------------------
module mcu_resq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  mcu_pkg::res_t               res_i,
  input  logic                        pop_i,
  output mcu_pkg::res_t               head_o,
  output logic                        empty_o,
  output logic [mcu_pkg::ResCntW-1:0] count_o
);

  mcu_pkg::res_t               mem_q [mcu_pkg::ResDepth];
  logic [mcu_pkg::ResPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [mcu_pkg::ResCntW-1:0] count_q;
  logic                        do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign do_push = push_i & (count_q != mcu_pkg::ResCntW'(mcu_pkg::ResDepth));
  assign do_pop  = pop_i & ~empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + mcu_pkg::ResCntW'(do_push) - mcu_pkg::ResCntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

// ===== rtl/monotone_cubic_upsampler_top.sv =====
// ----------------------------------------------------------------------------
// Monotone cubic upsampler
// The first word of a released gap goes through the command queue, the back
// end's multiply stage register and the result queue if the back end is free.
// That stage issues one word per cycle while the result queue has room:
// SUBSTEPS words per gap and up to 2*SUBSTEPS+1 for a window's last sample.
// Reset is asynchronous and clears all control state at once.
// ----------------------------------------------------------------------------
`include "monotone_cubic_upsampler_top_defines.svh"

module monotone_cubic_upsampler_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  logic [mcu_pkg::SampleW-1:0] sample_i,
  input  logic                     end_of_window_i,
  output logic                     empty,
  input  logic                     pop,
  output logic [mcu_pkg::SampleW-1:0] curve_value_o,
  output logic [mcu_pkg::PosW-1:0] position_o,
  output logic                     final_res_o
);

  mcu_pkg::cmd_t               front_cmd, head_cmd;
  logic                        front_push, back_pop;
  mcu_pkg::q_stat_t            cmd_stat;
  logic                        res_push;
  mcu_pkg::res_t               back_res, head_res;
  logic [mcu_pkg::ResCntW-1:0] res_count;

  mcu_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .sample_i       (sample_i),
    .end_of_window_i(end_of_window_i),
    .cmd_full_i     (cmd_stat.full),
    .cmd_push_o     (front_push),
    .cmd_o          (front_cmd)
  );

  mcu_cmdq u_cmdq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(front_push),
    .cmd_i (front_cmd),
    .pop_i (back_pop),
    .head_o(head_cmd),
    .stat_o(cmd_stat)
  );

  mcu_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (head_cmd),
    .cmd_valid_i(~cmd_stat.empty),
    .cmd_pop_o  (back_pop),
    .res_count_i(res_count),
    .res_push_o (res_push),
    .res_o      (back_res)
  );

  mcu_resq u_resq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .res_i  (back_res),
    .pop_i  (pop),
    .head_o (head_res),
    .empty_o(empty),
    .count_o(res_count)
  );

  assign full          = cmd_stat.full;
  assign curve_value_o = head_res.value;
  assign position_o    = head_res.pos;
  assign final_res_o   = head_res.fin;

  `MCU_NEVER(a_value_range, !empty && (curve_value_o > mcu_pkg::SampleW'(mcu_pkg::ValMax)), "word value above full scale")
  `MCU_ASSERT(a_end_queued, push && !full && end_of_window_i |=> !cmd_stat.empty, "window end word not queued")
  `MCU_ASSERT(a_pos_order, !empty && pop && !final_res_o |=> empty || (position_o >= $past(position_o)), "position went backward inside a window")
  `MCU_NEVER(a_res_overflow, res_push && (res_count == mcu_pkg::ResCntW'(mcu_pkg::ResDepth)), "word written into a full result queue")

endmodule
